/* sv/event_refractory_and_neighbour_filter_defines.svh */
// ---------------------------------------------------------------------------
// Event filter assertion macros
// Shared property forms for the event filter checks, clocked on clk and
// disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef EVENT_REFRACTORY_AND_NEIGHBOUR_FILTER_DEFINES_SVH
`define EVENT_REFRACTORY_AND_NEIGHBOUR_FILTER_DEFINES_SVH

// same-cycle implication
`define ERF_ASSERT_NOW(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication
`define ERF_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

/* sv/erf_pkg.sv */
// ---------------------------------------------------------------------------
// Event filter package
// Sizes, register indexes and shared types of the event filter.
// ---------------------------------------------------------------------------
`default_nettype none

package erf_pkg;

	localparam int MAX_WIDTH   = 512;
	localparam int MAX_HEIGHT  = 512;
	localparam int MAX_RADIUS  = 3;
	localparam int STAMP_BITS  = 32;

	localparam int COL_BITS    = $clog2(MAX_WIDTH);
	localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
	localparam int ADDR_BITS   = COL_BITS + ROW_BITS;
	localparam int WORD_BITS   = STAMP_BITS + 1;
	localparam int IN_STAMP_BITS = 31;
	localparam int WINDOW_BITS = 31;
	localparam int RADIUS_BITS = 2;
	localparam int FRAME_BITS  = 10;

	localparam int IN_FIELD_BITS  = COL_BITS + ROW_BITS + 1 + IN_STAMP_BITS;
	localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_BITS = 8;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 31;

	// configuration register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_TEMPORAL_ENABLE = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TEMPORAL_WINDOW = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPATIAL_ENABLE  = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPATIAL_WINDOW  = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPATIAL_RADIUS  = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH     = 3'd5;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT    = 3'd6;

	// flags from the age compare unit
	typedef struct packed {
		logic below;
		logic nonzero;
	} age_flags_t;

endpackage

`default_nettype wire

/* sv/erf_age_unit.sv */
// ---------------------------------------------------------------------------
// Event filter age compare unit
// Signed age of a stored stamp against the event stamp, compared with a
// window; shared by the refractory check and the neighborhood scan.
// ---------------------------------------------------------------------------
`default_nettype none

module erf_age_unit
	import erf_pkg::*;
(
	input  wire logic [IN_STAMP_BITS-1:0] stamp,
	input  wire logic [STAMP_BITS-1:0]    entry,
	input  wire logic [WINDOW_BITS-1:0]   window,
	output      age_flags_t               flags
);

	logic [STAMP_BITS-1:0] age;
	logic [STAMP_BITS-1:0] window_x;

	// age wraps modulo the stamp width and reads as signed
	assign age      = STAMP_BITS'(stamp) - entry;
	assign window_x = STAMP_BITS'(window);

	assign flags.below   = $signed(age) < $signed(window_x);
	assign flags.nonzero = |age;

endmodule

`default_nettype wire

/* sv/event_refractory_and_neighbour_filter.sv */
// ---------------------------------------------------------------------------
// Event refractory and neighborhood filter
// Decides per address event whether it passes a refractory test on its own
// pixel and a support test over the square neighborhood round it.
// ---------------------------------------------------------------------------
// Input words arrive on s_axis (col, row, polarity, stamp); one pass flag
// per word leaves on m_axis. The user must see that registers are written
// through cfg_we / cfg_index / cfg_data only while no word is in flight;
// the block itself does not enforce it.
// After reset the pixel store (one 33-bit word per pixel: stamp and
// polarity) is swept to zero, one entry per cycle, with s_axis_tready
// low. Then one word is taken at a time, s_axis_tready low until its
// flag is loaded into the output register. An out-of-frame word goes
// straight to the output; otherwise its pixel is read and checked, and
// unless it is dropped as refractory or the scan is off, every pixel of
// the clipped neighborhood (up to 49 at radius 3) is read in turn.
// The single-port store gives one neighbor read per cycle, each read
// age checked by one shared subtract-and-compare unit.
// A stalled m_axis holds the flag in the output register; the next word is
// still accepted and worked on, and waits at its end for the register.
// ---------------------------------------------------------------------------
`default_nettype none

module event_refractory_and_neighbour_filter
	import erf_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// s_axis_tdata: col[8:0], row[17:9], polarity[18], stamp[49:19], zeros above
	input  wire logic                      s_axis_tvalid,
	output      logic                      s_axis_tready,
	input  wire logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
	// m_axis_tdata: pass[0], zeros above
	output      logic                      m_axis_tvalid,
	input  wire logic                      m_axis_tready,
	output      logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
	input  wire logic                      cfg_we,
	input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_RDC   = 7'b0000100,
		S_CHK   = 7'b0001000,
		S_SCAN  = 7'b0010000,
		S_TAIL  = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t state_q;

	// configuration
	logic                   temporal_enable_q;
	logic [WINDOW_BITS-1:0] temporal_window_q;
	logic                   spatial_enable_q;
	logic [WINDOW_BITS-1:0] spatial_window_q;
	logic [RADIUS_BITS-1:0] spatial_radius_q;
	logic [FRAME_BITS-1:0]  frame_width_q;
	logic [FRAME_BITS-1:0]  frame_height_q;

	// input word fields
	logic [COL_BITS-1:0]      in_col;
	logic [ROW_BITS-1:0]      in_row;
	logic                     in_pol;
	logic [IN_STAMP_BITS-1:0] in_stamp;

	assign in_col   = s_axis_tdata[COL_BITS-1:0];
	assign in_row   = s_axis_tdata[COL_BITS+ROW_BITS-1:COL_BITS];
	assign in_pol   = s_axis_tdata[COL_BITS+ROW_BITS];
	assign in_stamp = s_axis_tdata[IN_FIELD_BITS-1:COL_BITS+ROW_BITS+1];

	// event registers
	logic [COL_BITS-1:0]      col_q;
	logic [ROW_BITS-1:0]      row_q;
	logic                     pol_q;
	logic [IN_STAMP_BITS-1:0] stamp_q;
	logic [COL_BITS-1:0]      col_lo_q, col_hi_q, ci_q;
	logic [ROW_BITS-1:0]      row_lo_q, row_hi_q, ri_q;
	logic                     hit_q;
	logic                     rd_pend_s1;
	logic [ADDR_BITS-1:0]     clr_q;

	logic                     m_tvalid_q;
	logic                     m_pass_q;

	// frame clip and neighborhood bounds
	logic [FRAME_BITS-1:0]  w_clip, h_clip, w_last, h_last;
	logic [RADIUS_BITS-1:0] r_clip;
	logic [FRAME_BITS-1:0]  r_x, col_x, row_x, col_up, row_up;
	logic [FRAME_BITS-1:0]  col_lo, col_hi, row_lo, row_hi;
	logic                   in_frame;

	assign w_clip = (frame_width_q > FRAME_BITS'(MAX_WIDTH)) ?
		FRAME_BITS'(MAX_WIDTH) : frame_width_q;
	assign h_clip = (frame_height_q > FRAME_BITS'(MAX_HEIGHT)) ?
		FRAME_BITS'(MAX_HEIGHT) : frame_height_q;
	assign r_clip = (spatial_radius_q > RADIUS_BITS'(MAX_RADIUS)) ?
		RADIUS_BITS'(MAX_RADIUS) : spatial_radius_q;
	assign w_last = w_clip - FRAME_BITS'(1);
	assign h_last = h_clip - FRAME_BITS'(1);
	assign r_x    = FRAME_BITS'(r_clip);
	assign col_x  = FRAME_BITS'(in_col);
	assign row_x  = FRAME_BITS'(in_row);
	assign col_up = col_x + r_x;
	assign row_up = row_x + r_x;
	assign col_lo = (col_x > r_x) ? col_x - r_x : '0;
	assign row_lo = (row_x > r_x) ? row_x - r_x : '0;
	assign col_hi = (col_up < w_last) ? col_up : w_last;
	assign row_hi = (row_up < h_last) ? row_up : h_last;
	assign in_frame = (col_x < w_clip) && (row_x < h_clip);

	// pixel store
	logic [WORD_BITS-1:0] store_mem [2**ADDR_BITS];
	logic [WORD_BITS-1:0] rd_data_q;
	logic                 mem_we, mem_re;
	logic [ADDR_BITS-1:0] mem_addr;
	logic [WORD_BITS-1:0] mem_wdata;

	// shared age unit
	age_flags_t             age_flags;
	logic [WINDOW_BITS-1:0] age_window;
	logic                   refractory_drop;
	logic                   out_free;
	logic                   accept;

	assign age_window = (state_q == S_CHK) ? temporal_window_q : spatial_window_q;

	erf_age_unit u_age (
		.stamp  (stamp_q),
		.entry  (rd_data_q[STAMP_BITS-1:0]),
		.window (age_window),
		.flags  (age_flags)
	);

	assign refractory_drop = temporal_enable_q && (rd_data_q[STAMP_BITS] == pol_q) &&
		age_flags.below;
	assign out_free = !m_tvalid_q || m_axis_tready;
	assign accept   = s_axis_tvalid && s_axis_tready;

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = OUT_TDATA_BITS'(m_pass_q);

	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = {row_q, col_q};
		mem_wdata = {pol_q, STAMP_BITS'(stamp_q)};
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_addr  = clr_q;
				mem_wdata = '0;
			end
			S_RDC: begin
				mem_re = 1'b1;
			end
			S_CHK: begin
				mem_we = 1'b1;
				// refractory drop refreshes the stamp only
				if (refractory_drop) begin
					mem_wdata = {rd_data_q[STAMP_BITS], STAMP_BITS'(stamp_q)};
				end
			end
			S_SCAN: begin
				mem_re   = 1'b1;
				mem_addr = {ri_q, ci_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[mem_addr] <= mem_wdata;
		end else if (mem_re) begin
			rd_data_q <= store_mem[mem_addr];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temporal_enable_q <= 1'b0;
			temporal_window_q <= '0;
			spatial_enable_q  <= 1'b0;
			spatial_window_q  <= '0;
			spatial_radius_q  <= RADIUS_BITS'(1);
			frame_width_q     <= FRAME_BITS'(MAX_WIDTH);
			frame_height_q    <= FRAME_BITS'(MAX_HEIGHT);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TEMPORAL_ENABLE: temporal_enable_q <= cfg_data[0];
				REG_TEMPORAL_WINDOW: temporal_window_q <= cfg_data[WINDOW_BITS-1:0];
				REG_SPATIAL_ENABLE:  spatial_enable_q  <= cfg_data[0];
				REG_SPATIAL_WINDOW:  spatial_window_q  <= cfg_data[WINDOW_BITS-1:0];
				REG_SPATIAL_RADIUS:  spatial_radius_q  <= cfg_data[RADIUS_BITS-1:0];
				REG_FRAME_WIDTH:     frame_width_q     <= cfg_data[FRAME_BITS-1:0];
				REG_FRAME_HEIGHT:    frame_height_q    <= cfg_data[FRAME_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// event payload
	always_ff @(posedge clk) begin
		if (accept) begin
			col_q    <= in_col;
			row_q    <= in_row;
			pol_q    <= in_pol;
			stamp_q  <= in_stamp;
			col_lo_q <= col_lo[COL_BITS-1:0];
			col_hi_q <= col_hi[COL_BITS-1:0];
			row_lo_q <= row_lo[ROW_BITS-1:0];
			row_hi_q <= row_hi[ROW_BITS-1:0];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			ci_q       <= '0;
			ri_q       <= '0;
			hit_q      <= 1'b0;
			rd_pend_s1 <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_pass_q   <= 1'b0;
		end else begin
			rd_pend_s1 <= (state_q == S_SCAN);
			if (rd_pend_s1 && age_flags.nonzero && age_flags.below) begin
				hit_q <= 1'b1;
			end
			// a finishing word reloads the register below instead
			if (m_tvalid_q && m_axis_tready && (state_q != S_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + ADDR_BITS'(1);
					if (&clr_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						hit_q   <= 1'b0;
						state_q <= in_frame ? S_RDC : S_DONE;
					end
				end
				S_RDC: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					ci_q <= col_lo_q;
					ri_q <= row_lo_q;
					if (refractory_drop) begin
						hit_q   <= 1'b0;
						state_q <= S_DONE;
					end else if (!spatial_enable_q) begin
						hit_q   <= 1'b1;
						state_q <= S_DONE;
					end else begin
						hit_q   <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// advance rows inside a column, then the next column
					if (ri_q == row_hi_q) begin
						ri_q <= row_lo_q;
						ci_q <= ci_q + COL_BITS'(1);
						if (ci_q == col_hi_q) begin
							state_q <= S_TAIL;
						end
					end else begin
						ri_q <= ri_q + ROW_BITS'(1);
					end
				end
				S_TAIL: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					// hold the flag until the output register frees
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_pass_q   <= hit_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`include "event_refractory_and_neighbour_filter_defines.svh"

	`ERF_ASSERT_NEXT(a_busy_after_accept, accept, !s_axis_tready, "input taken while busy")
	`ERF_ASSERT_NEXT(a_done_loads_output, (state_q == S_DONE) && out_free, m_axis_tvalid && s_axis_tready, "finished flag not loaded")
	`ERF_ASSERT_NOW(a_read_in_scan, rd_pend_s1, (state_q == S_SCAN) || (state_q == S_TAIL), "neighbor read outside scan")
	`ERF_ASSERT_NOW(a_write_phase, mem_we, (state_q == S_CLEAR) || (state_q == S_CHK), "store written outside clear or check")

endmodule

`default_nettype wire
